>>> design/fscd_pkg.sv
// ----------------------------------------------------------------------------
// fscd_pkg: shared types and constants for the sine/cosine pipeline
// Item types for the angle and result channels, fixed-point constants and
// constant reciprocals used by the division-free reduction steps.
// ----------------------------------------------------------------------------
package fscd_pkg;

    localparam int ANGLE_W     = 32;
    localparam int TRIG_W      = 16;
    localparam int MAG_W       = 24;
    localparam int LANE_STAGES = 11;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES = FRONT_STAGES + LANE_STAGES;

    // Integer degrees are biased by 92 turns so the residue is taken on a
    // positive value.
    localparam logic [16:0] HI_BIAS   = 17'd33120;
    localparam logic [15:0] RECIP_360 = 16'd46603;   // floor(2^24 / 360)
    localparam logic [8:0]  DEG_TURN_U = 9'd360;

    localparam logic signed [9:0] DEG_TURN    = 10'sd360;
    localparam logic signed [9:0] DEG_HALF    = 10'sd180;
    localparam logic signed [9:0] DEG_QUARTER = 10'sd90;

    // 180 degrees in Q8.16
    localparam logic [MAG_W-1:0] HALF_TURN_Q16 = 24'd11796480;

    // First estimate: y = (t*(K-t) + 16200) / 32400, taken as
    // ((t*(K-t) + 16200) >> 4) / 2025.
    localparam logic [13:0] EST_BIAS   = 14'd16200;
    localparam logic [30:0] RECIP_2025 = 31'd1085937410;  // floor(2^41 / 2025)
    localparam logic [10:0] EST_DIV    = 11'd2025;

    // Refinement: p = (9*w + 20) / 40, taken as ((9*w + 20) >> 3) / 5.
    localparam logic [3:0]  REFINE_MUL  = 4'd9;
    localparam logic [4:0]  REFINE_BIAS = 5'd20;
    localparam logic [29:0] RECIP_5     = 30'd858993459;  // floor(2^32 / 5)
    localparam logic [2:0]  DIV_5       = 3'd5;

    localparam logic [14:0] Q15_HALF = 15'd16384;
    localparam logic [TRIG_W-1:0] TRIG_MAX = 16'h7FFF;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_deg;
    } t_angle_item;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sine;
        logic signed [TRIG_W-1:0] cosine;
    } t_trig_item;

endpackage

>>> design/fscd_stream_if.sv
// ----------------------------------------------------------------------------
// fscd_stream_if: valid/ready stream channel
// Carries one payload item per transaction; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface fscd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/fscd_lane.sv
// ----------------------------------------------------------------------------
// fscd_lane: parabolic estimate and refinement for one output
// Eleven-stage datapath from an angle magnitude in Q8.16 degrees to a signed,
// saturated Q1.15 result. All stages advance together on i_en.
// ----------------------------------------------------------------------------
module fscd_lane (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [fscd_pkg::MAG_W-1:0]       i_mag,
    input  logic                             i_neg,
    output logic signed [fscd_pkg::TRIG_W-1:0] o_res
);
    import fscd_pkg::*;

    // stage 1: t*(K-t)
    logic [44:0] n_p,   r_p;
    // stage 2: biased and scaled down
    logic [45:0] l2_sum;
    logic [40:0] n_s,   r_s;
    // stage 3: reciprocal partial products
    logic [50:0] n_pph, r_pph;
    logic [51:0] n_ppl, r_ppl;
    logic [40:0] r_s3;
    // stage 4: quotient estimate
    logic [71:0] l4_acc;
    logic [30:0] n_qe,  r_qe;
    logic [40:0] r_s4;
    // stage 5: back-multiply
    logic [41:0] n_m,   r_m;
    logic [30:0] r_qe5;
    logic [40:0] r_s5;
    // stage 6: corrected estimate y
    logic [41:0] l6_diff;
    logic [30:0] n_u,   r_u;
    // stage 7: y*y
    logic [61:0] l7_sq;
    logic [30:0] n_v,   r_v;
    logic [30:0] r_u7;
    // stage 8: refinement numerator
    logic [28:0] l8_w;
    logic [31:0] l8_t;
    logic [28:0] n_x,   r_x;
    logic [30:0] r_u8;
    // stage 9: divide by five, estimate
    logic [58:0] l9_prod;
    logic [26:0] n_q5,  r_q5;
    logic [28:0] r_x9;
    logic [30:0] r_u9;
    // stage 10: correction and z
    logic [28:0] l10_rem;
    logic [26:0] l10_p;
    logic [30:0] n_z,   r_z;
    // stage 11: round, sign, saturate
    logic [31:0] l11_round;
    logic [15:0] l11_q;
    logic signed [TRIG_W-1:0] n_res, r_res;

    logic [9:0] r_neg;

    always_comb begin
        n_p = 45'(i_mag * (HALF_TURN_Q16 - i_mag));

        l2_sum = {1'b0, r_p} + 46'(EST_BIAS);
        n_s    = l2_sum[44:4];

        n_pph = 51'(r_s[40:21] * RECIP_2025);
        n_ppl = 52'(r_s[20:0] * RECIP_2025);

        l4_acc = {r_pph, 21'b0} + 72'(r_ppl);
        n_qe   = l4_acc[71:41];

        n_m = 42'(r_qe * EST_DIV);

        // estimate is low by at most one
        l6_diff = {1'b0, r_s5} - r_m;
        n_u     = r_qe5 + 31'(l6_diff[11:0] >= 12'(EST_DIV));

        l7_sq = 62'(r_u * r_u);
        n_v   = l7_sq[60:30];

        l8_w = 29'(r_u7 - r_v);
        l8_t = 32'(l8_w * REFINE_MUL) + 32'(REFINE_BIAS);
        n_x  = l8_t[31:3];

        l9_prod = 59'(r_x * RECIP_5);
        n_q5    = l9_prod[58:32];

        l10_rem = r_x9 - 29'(r_q5 * DIV_5);
        l10_p   = r_q5 + 27'(l10_rem >= 29'(DIV_5));
        n_z     = r_u9 - 31'(l10_p);

        l11_round = 32'(r_z) + 32'(Q15_HALF);
        l11_q     = l11_round[30:15];
        if (r_neg[9]) begin
            n_res = signed'(16'(-l11_q));
        end else if (l11_q[15]) begin
            n_res = signed'(TRIG_MAX);
        end else begin
            n_res = signed'(l11_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_s   <= n_s;
            r_pph <= n_pph;
            r_ppl <= n_ppl;
            r_s3  <= r_s;
            r_qe  <= n_qe;
            r_s4  <= r_s3;
            r_m   <= n_m;
            r_qe5 <= r_qe;
            r_s5  <= r_s4;
            r_u   <= n_u;
            r_v   <= n_v;
            r_u7  <= r_u;
            r_x   <= n_x;
            r_u8  <= r_u7;
            r_q5  <= n_q5;
            r_x9  <= r_x;
            r_u9  <= r_u8;
            r_z   <= n_z;
            r_res <= n_res;
            r_neg <= {r_neg[8:0], i_neg};
        end
    end

    assign o_res = r_res;

endmodule

>>> design/fast_sine_cosine_degrees.sv
// ----------------------------------------------------------------------------
// fast_sine_cosine_degrees: pipelined parabolic sine and cosine
// Takes one angle per transaction in signed Q16.16 degrees and returns its
// sine and cosine as signed Q1.15, saturated, with one result transaction
// per angle. Any 32-bit angle is valid; it is reduced modulo 360 degrees into
// (-180, 180], and cosine is evaluated as the sine rule at angle + 90 degrees.
// The block accepts one angle every cycle while the skid entry is empty; each
// angle passes through three stages of angle reduction and an eleven-stage
// estimate/refine datapath per output, whose constant divisions by 360, 2025
// and 5 are reciprocal multiplies with one correction step each. An output
// register with a one-entry skid buffer keeps the input ready independent
// of the output ready; a stall holds the pipeline only once the skid entry
// is occupied.
// ----------------------------------------------------------------------------
module fast_sine_cosine_degrees (
    input  logic i_clk,
    input  logic i_rst_n,
    fscd_stream_if.sink   i_angle,
    fscd_stream_if.source o_trig
);
    import fscd_pkg::*;

    logic w_en;
    logic [PIPE_STAGES-1:0] r_v;

    // stage 1: integer degrees biased positive, reciprocal multiply by 1/360
    logic [15:0] s1_hi;
    logic [16:0] n1_h,  r1_h;
    logic [31:0] n1_mq, r1_mq;
    logic [15:0] r1_lo;

    // stage 2: residue modulo 360
    logic [7:0]  s2_q;
    logic [16:0] s2_t;
    logic [9:0]  s2_rem;
    logic [8:0]  n2_rem, r2_rem;
    logic [15:0] r2_lo;

    // stage 3: wrap into (-180, 180], cosine phase, magnitudes
    logic              s3_frac;
    logic signed [9:0] s3_rem, s3_d, s3_c0, s3_c;
    logic signed [25:0] s3_dv, s3_cv;
    logic [MAG_W-1:0]  n3_mag_s, r3_mag_s, n3_mag_c, r3_mag_c;
    logic              n3_neg_s, r3_neg_s, n3_neg_c, r3_neg_c;

    logic signed [TRIG_W-1:0] w_sine, w_cosine;
    t_trig_item w_head;

    t_trig_item n_out, r_out, n_skid, r_skid;
    logic       n_out_v, r_out_v, n_skid_v, r_skid_v;

    assign w_en = !r_skid_v;
    assign i_angle.ready = w_en;

    always_comb begin
        s1_hi = i_angle.data.angle_deg[31:16];
        n1_h  = {s1_hi[15], s1_hi} + HI_BIAS;
        n1_mq = 32'(n1_h * RECIP_360);
    end

    always_comb begin
        s2_q   = r1_mq[31:24];
        s2_t   = r1_h - 17'(s2_q * DEG_TURN_U);
        s2_rem = s2_t[9:0];
        // quotient estimate is low by at most one
        n2_rem = (s2_rem >= {1'b0, DEG_TURN_U}) ? 9'(s2_rem - {1'b0, DEG_TURN_U})
                                                : s2_rem[8:0];
    end

    always_comb begin
        s3_frac = |r2_lo;
        s3_rem  = signed'({1'b0, r2_rem});
        s3_d    = (s3_rem > DEG_HALF || (s3_rem == DEG_HALF && s3_frac))
                  ? s3_rem - DEG_TURN : s3_rem;
        s3_c0   = s3_d + DEG_QUARTER;
        s3_c    = (s3_c0 > DEG_HALF || (s3_c0 == DEG_HALF && s3_frac))
                  ? s3_c0 - DEG_TURN : s3_c0;
        s3_dv   = signed'({s3_d, r2_lo});
        s3_cv   = signed'({s3_c, r2_lo});
        n3_neg_s = s3_d[9];
        n3_neg_c = s3_c[9];
        n3_mag_s = s3_d[9] ? 24'(-s3_dv) : s3_dv[MAG_W-1:0];
        n3_mag_c = s3_c[9] ? 24'(-s3_cv) : s3_cv[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_h     <= n1_h;
            r1_mq    <= n1_mq;
            r1_lo    <= i_angle.data.angle_deg[15:0];
            r2_rem   <= n2_rem;
            r2_lo    <= r1_lo;
            r3_mag_s <= n3_mag_s;
            r3_neg_s <= n3_neg_s;
            r3_mag_c <= n3_mag_c;
            r3_neg_c <= n3_neg_c;
        end
    end

    fscd_lane u_sine (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r3_mag_s),
        .i_neg (r3_neg_s),
        .o_res (w_sine)
    );

    fscd_lane u_cosine (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r3_mag_c),
        .i_neg (r3_neg_c),
        .o_res (w_cosine)
    );

    always_comb begin
        w_head.sine   = w_sine;
        w_head.cosine = w_cosine;
    end

    // Output register and skid entry
    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (!r_out_v || o_trig.ready) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else if (w_en && r_v[PIPE_STAGES-1]) begin
                n_out   = w_head;
                n_out_v = 1'b1;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (w_en && r_v[PIPE_STAGES-1]) begin
            // hold the waiting transaction, park the new one
            n_skid   = w_head;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[PIPE_STAGES-2:0], i_angle.valid};
            end
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_trig.valid = r_out_v;
    assign o_trig.data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry occupied while output register is empty");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v))
        else $error("pipeline advanced while skid entry was occupied");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_trig.valid && o_trig.ready && !r_skid_v && !r_v[PIPE_STAGES-1])
        |=> !o_trig.valid)
        else $error("output valid without a pending result");

endmodule
